FILE: design/eap_pkg.sv
// Package for the Euler attitude propagation block: number formats, CORDIC and
// divider constants, and fixed-point helper functions.
// No dependencies.
package eap_pkg;

    // CORDIC in Q30 for x/y, Q28 for angles, 34-bit signed datapath
    localparam int CW               = 34;
    localparam int CORDIC_STEPS     = 24;
    localparam int CORDIC_PER_STAGE = 4;
    localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
    // prep stage, rotation stages, rounding stage
    localparam int CORDIC_LAT       = CORDIC_STAGES + 2;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] PI_Q28      = 34'sd843314857;
    localparam logic signed [CW-1:0] TWO_PI_Q28  = 34'sd1686629713;
    localparam logic signed [CW-1:0] HALF_PI_Q28 = 34'sd421657428;

    // restoring divider: 34 quotient bits, 20-bit divisor
    localparam int DIV_W         = 34;
    localparam int DEN_W         = 20;
    localparam int DIV_PER_STAGE = 2;
    localparam int DIV_STAGES    = DIV_W / DIV_PER_STAGE;
    localparam int DIV_LAT       = DIV_STAGES + 1;

    localparam logic [15:0] SAMPLE_PERIOD_RESET = 16'd655;

    function automatic logic signed [CW-1:0] atan_q28(input logic [4:0] idx);
        logic signed [CW-1:0] a;
        unique case (idx)
            5'd0:  a = 34'sd210828714;
            5'd1:  a = 34'sd124459457;
            5'd2:  a = 34'sd65760959;
            5'd3:  a = 34'sd33381290;
            5'd4:  a = 34'sd16755422;
            5'd5:  a = 34'sd8385879;
            5'd6:  a = 34'sd4193963;
            5'd7:  a = 34'sd2097109;
            5'd8:  a = 34'sd1048571;
            5'd9:  a = 34'sd524287;
            5'd10: a = 34'sd262144;
            5'd11: a = 34'sd131072;
            5'd12: a = 34'sd65536;
            5'd13: a = 34'sd32768;
            5'd14: a = 34'sd16384;
            5'd15: a = 34'sd8192;
            5'd16: a = 34'sd4096;
            5'd17: a = 34'sd2048;
            5'd18: a = 34'sd1024;
            5'd19: a = 34'sd512;
            5'd20: a = 34'sd256;
            5'd21: a = 34'sd128;
            5'd22: a = 34'sd64;
            5'd23: a = 34'sd32;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Q15.16 product: floor shift by 16, saturate to 32 bits
    function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        logic signed [47:0] s;
        p = 64'(a) * 64'(b);
        s = 48'(p >>> 16);
        if (s > 48'sh7fff_ffff) begin
            return 32'sh7fff_ffff;
        end else if (s < -48'sh8000_0000) begin
            return 32'sh8000_0000;
        end
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sh7fff_ffff) begin
            return 32'sh7fff_ffff;
        end else if (v < -34'sh8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Q16 sum back to a Q3.12 angle with floor and saturation
    function automatic logic signed [15:0] angle16(input logic signed [33:0] v);
        logic signed [33:0] s;
        s = v >>> 4;
        if (s > 34'sh7fff) begin
            return 16'sh7fff;
        end else if (s < -34'sh8000) begin
            return 16'sh8000;
        end
        return s[15:0];
    endfunction

endpackage

FILE: design/eap_if.sv
// Valid/ready channel interfaces for the Euler attitude propagation block:
// input item, result item and sample period write.
// No dependencies.
interface eap_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_in;
    logic signed [15:0] pitch_in;
    logic signed [15:0] yaw_in;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;

    modport source (output valid, roll_in, pitch_in, yaw_in, rate_x, rate_y, rate_z,
                    input ready);
    modport sink   (input valid, roll_in, pitch_in, yaw_in, rate_x, rate_y, rate_z,
                    output ready);
endinterface

interface eap_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_out;
    logic signed [15:0] pitch_out;
    logic signed [15:0] yaw_out;
    logic signed [31:0] jac_roll_roll;
    logic signed [31:0] jac_roll_pitch;
    logic signed [31:0] jac_pitch_roll;
    logic signed [31:0] jac_yaw_roll;
    logic signed [31:0] jac_yaw_pitch;
    logic               singular;

    modport source (output valid, roll_out, pitch_out, yaw_out, jac_roll_roll,
                    jac_roll_pitch, jac_pitch_roll, jac_yaw_roll, jac_yaw_pitch,
                    singular, input ready);
    modport sink   (input valid, roll_out, pitch_out, yaw_out, jac_roll_roll,
                    jac_roll_pitch, jac_pitch_roll, jac_yaw_roll, jac_yaw_pitch,
                    singular, output ready);
endinterface

interface eap_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

FILE: design/eap_cordic.sv
// Pipelined rotation CORDIC: Q3.12 angle in, Q16 sine and cosine out.
// Depends on eap_pkg. The prep, rotation and rounding registers advance only while i_en is high.
module eap_cordic (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_ang,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);
    import eap_pkg::*;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 neg;
    } t_rot;

    t_rot                 r_st [CORDIC_STAGES+1];
    t_rot                 n_prep;
    logic signed [CW-1:0] z_raw;
    logic signed [CW-1:0] z_wrap;
    logic signed [CW-1:0] x_rnd;
    logic signed [CW-1:0] y_rnd;
    logic signed [31:0]   r_sin;
    logic signed [31:0]   r_cos;

    // wrap once by 2*pi, then fold into [-pi/2, pi/2]
    always_comb begin
        z_raw = CW'(i_ang) <<< 16;
        if (z_raw > PI_Q28) begin
            z_wrap = z_raw - TWO_PI_Q28;
        end else if (z_raw < -PI_Q28) begin
            z_wrap = z_raw + TWO_PI_Q28;
        end else begin
            z_wrap = z_raw;
        end
        n_prep.x   = CORDIC_GAIN;
        n_prep.y   = '0;
        n_prep.neg = 1'b0;
        n_prep.z   = z_wrap;
        if (z_wrap > HALF_PI_Q28) begin
            n_prep.z   = z_wrap - PI_Q28;
            n_prep.neg = 1'b1;
        end else if (z_wrap < -HALF_PI_Q28) begin
            n_prep.z   = z_wrap + PI_Q28;
            n_prep.neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= n_prep;
        end
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
        t_rot                 n_step;
        logic signed [CW-1:0] x_tmp;

        always_comb begin
            int sh;
            n_step = r_st[g];
            x_tmp  = n_step.x;
            for (int j = 0; j < CORDIC_PER_STAGE; j++) begin
                sh = g * CORDIC_PER_STAGE + j;
                if (!n_step.z[CW-1]) begin
                    x_tmp    = n_step.x - (n_step.y >>> sh);
                    n_step.y = n_step.y + (n_step.x >>> sh);
                    n_step.z = n_step.z - atan_q28(5'(sh));
                end else begin
                    x_tmp    = n_step.x + (n_step.y >>> sh);
                    n_step.y = n_step.y - (n_step.x >>> sh);
                    n_step.z = n_step.z + atan_q28(5'(sh));
                end
                n_step.x = x_tmp;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[g+1] <= n_step;
            end
        end
    end

    // round Q30 to Q16, undo the fold
    always_comb begin
        x_rnd = (r_st[CORDIC_STAGES].x + 34'sd8192) >>> 14;
        y_rnd = (r_st[CORDIC_STAGES].y + 34'sd8192) >>> 14;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= r_st[CORDIC_STAGES].neg ? 32'(-y_rnd) : 32'(y_rnd);
            r_cos <= r_st[CORDIC_STAGES].neg ? 32'(-x_rnd) : 32'(x_rnd);
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

FILE: design/eap_div.sv
// Pipelined restoring divider, truncating, saturated to a signed 32-bit quotient.
// Depends on eap_pkg. The divider stages and the output register advance only while i_en is high.
module eap_div (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [33:0]        i_num,
    input  logic [19:0]        i_den,
    input  logic               i_neg,
    output logic signed [31:0] o_quo
);
    import eap_pkg::*;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [DIV_W-1:0] qn;
        logic [DEN_W-1:0] den;
        logic             neg;
    } t_div;

    t_div               r_st [DIV_STAGES];
    t_div               w_in [DIV_STAGES];
    logic signed [31:0] r_quo;
    logic [DIV_W-1:0]   q_fin;

    assign w_in[0] = '{rem: '0, qn: i_num, den: i_den, neg: i_neg};

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        t_div n_step;

        if (g > 0) begin : g_link
            assign w_in[g] = r_st[g-1];
        end

        always_comb begin
            logic [DEN_W:0] shifted;
            n_step = w_in[g];
            for (int j = 0; j < DIV_PER_STAGE; j++) begin
                shifted = {n_step.rem, n_step.qn[DIV_W-1]};
                if (shifted >= {1'b0, n_step.den}) begin
                    n_step.rem = DEN_W'(shifted - {1'b0, n_step.den});
                    n_step.qn  = {n_step.qn[DIV_W-2:0], 1'b1};
                end else begin
                    n_step.rem = shifted[DEN_W-1:0];
                    n_step.qn  = {n_step.qn[DIV_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[g] <= n_step;
            end
        end
    end

    assign q_fin = r_st[DIV_STAGES-1].qn;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_st[DIV_STAGES-1].neg) begin
                r_quo <= (q_fin > 34'h0_8000_0000) ? 32'sh8000_0000 : 32'(-q_fin);
            end else begin
                r_quo <= (q_fin > 34'h0_7fff_ffff) ? 32'sh7fff_ffff : q_fin[31:0];
            end
        end
    end

    assign o_quo = r_quo;

endmodule

FILE: design/euler_attitude_propagation.sv
// Euler attitude propagation: one Euler-rate step plus five Jacobian terms.
// One item is accepted every cycle while the skid is empty; the pipeline depth
// comes from the 24-step CORDIC (four steps a stage) and the 34-bit divider for
// tan and sec (two quotient bits a stage). A one-deep skid holds a result the
// sink refuses; the whole pipe holds while the skid is full.
// Reset clears all valid bits and the skid and sets the sample period to 655.
module euler_attitude_propagation (
    input  logic i_clk,
    input  logic i_rst_n,
    eap_in_if.sink    i_item,
    eap_out_if.source o_result,
    eap_cfg_if.sink   i_cfg
);
    import eap_pkg::*;

    localparam int PIPE_LAT = CORDIC_LAT + DIV_LAT + 2;
    localparam int UV_DEPTH = DIV_LAT - 1;

    typedef struct packed {
        logic signed [19:0] roll;
        logic signed [19:0] pitch;
        logic signed [19:0] yaw;
        logic signed [21:0] dp;
        logic signed [21:0] dq;
        logic signed [21:0] dr;
    } t_side;

    typedef struct packed {
        logic signed [19:0] roll;
        logic signed [19:0] pitch;
        logic signed [19:0] yaw;
        logic signed [21:0] dp;
        logic signed [31:0] qs;
        logic signed [31:0] rc;
        logic signed [31:0] qc;
        logic signed [31:0] rs;
        logic               sing;
    } t_mid;

    typedef struct packed {
        logic signed [19:0] roll;
        logic signed [19:0] pitch;
        logic signed [19:0] yaw;
        logic signed [21:0] dp;
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic               sing;
    } t_uv;

    typedef struct packed {
        logic signed [19:0] roll;
        logic signed [19:0] pitch;
        logic signed [19:0] yaw;
        logic signed [21:0] dp;
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic signed [31:0] sc;
        logic signed [31:0] ut;
        logic signed [31:0] vt;
        logic signed [31:0] ssq;
        logic signed [31:0] usc;
        logic signed [31:0] vsc;
        logic               sing;
    } t_fin;

    typedef struct packed {
        logic signed [15:0] roll_out;
        logic signed [15:0] pitch_out;
        logic signed [15:0] yaw_out;
        logic signed [31:0] jrr;
        logic signed [31:0] jrp;
        logic signed [31:0] jpr;
        logic signed [31:0] jyr;
        logic signed [31:0] jyp;
        logic               sing;
    } t_res;

    logic [15:0]         r_sample_period;
    logic [PIPE_LAT-1:0] r_v;
    logic                r_skid_v;
    t_res                r_skid;
    t_side               r_side [CORDIC_LAT];
    t_side               n_side;
    t_mid                r_mid;
    t_uv                 r_uv [UV_DEPTH];
    t_fin                r_fin;
    t_res                r_out;
    t_res                res_sel;
    logic                en;
    logic                accept;
    logic signed [31:0]  sin_r, cos_r, sin_p, cos_p;
    logic signed [31:0]  tan_q, sec_q;
    logic [33:0]         tan_num;
    logic [19:0]         abs_sp, abs_cp;

    // dt (Q0.16) times a Q4.11 rate widened to Q16, floor shift by 11
    function automatic logic signed [21:0] dt_mul(input logic [15:0] dt,
                                                  input logic signed [15:0] rate);
        logic signed [32:0] p;
        p = 33'(signed'({1'b0, dt})) * 33'(rate);
        return 22'(p >>> 11);
    endfunction

    assign en     = !r_skid_v;
    assign accept = i_item.valid && en;
    assign i_item.ready = en;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_period <= SAMPLE_PERIOD_RESET;
        end else if (i_cfg.valid) begin
            r_sample_period <= i_cfg.data;
        end
    end

    always_comb begin
        n_side.roll  = 20'(i_item.roll_in) <<< 4;
        n_side.pitch = 20'(i_item.pitch_in) <<< 4;
        n_side.yaw   = 20'(i_item.yaw_in) <<< 4;
        n_side.dp    = dt_mul(r_sample_period, i_item.rate_x);
        n_side.dq    = dt_mul(r_sample_period, i_item.rate_y);
        n_side.dr    = dt_mul(r_sample_period, i_item.rate_z);
    end

    eap_cordic u_cordic_roll (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ang (i_item.roll_in),
        .o_sin (sin_r),
        .o_cos (cos_r)
    );

    eap_cordic u_cordic_pitch (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ang (i_item.pitch_in),
        .o_sin (sin_p),
        .o_cos (cos_p)
    );

    always_comb begin
        abs_sp  = sin_p[31] ? 20'(-sin_p) : sin_p[19:0];
        abs_cp  = cos_p[31] ? 20'(-cos_p) : cos_p[19:0];
        tan_num = 34'(abs_sp) << 16;
    end

    eap_div u_div_tan (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (tan_num),
        .i_den (abs_cp),
        .i_neg (sin_p[31] ^ cos_p[31]),
        .o_quo (tan_q)
    );

    eap_div u_div_sec (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (34'h1_0000_0000),
        .i_den (abs_cp),
        .i_neg (cos_p[31]),
        .o_quo (sec_q)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= n_side;
            for (int k = 1; k < CORDIC_LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end

            r_mid.roll  <= r_side[CORDIC_LAT-1].roll;
            r_mid.pitch <= r_side[CORDIC_LAT-1].pitch;
            r_mid.yaw   <= r_side[CORDIC_LAT-1].yaw;
            r_mid.dp    <= r_side[CORDIC_LAT-1].dp;
            r_mid.qs    <= mulq(32'(r_side[CORDIC_LAT-1].dq), sin_r);
            r_mid.rc    <= mulq(32'(r_side[CORDIC_LAT-1].dr), cos_r);
            r_mid.qc    <= mulq(32'(r_side[CORDIC_LAT-1].dq), cos_r);
            r_mid.rs    <= mulq(32'(r_side[CORDIC_LAT-1].dr), sin_r);
            r_mid.sing  <= (cos_p == '0);

            r_uv[0].roll  <= r_mid.roll;
            r_uv[0].pitch <= r_mid.pitch;
            r_uv[0].yaw   <= r_mid.yaw;
            r_uv[0].dp    <= r_mid.dp;
            r_uv[0].u     <= sat32(34'(r_mid.qs) + 34'(r_mid.rc));
            r_uv[0].v     <= sat32(34'(r_mid.qc) - 34'(r_mid.rs));
            r_uv[0].sing  <= r_mid.sing;
            for (int k = 1; k < UV_DEPTH; k++) begin
                r_uv[k] <= r_uv[k-1];
            end

            // tan and sec drop to zero for a singular pitch
            r_fin.roll  <= r_uv[UV_DEPTH-1].roll;
            r_fin.pitch <= r_uv[UV_DEPTH-1].pitch;
            r_fin.yaw   <= r_uv[UV_DEPTH-1].yaw;
            r_fin.dp    <= r_uv[UV_DEPTH-1].dp;
            r_fin.u     <= r_uv[UV_DEPTH-1].u;
            r_fin.v     <= r_uv[UV_DEPTH-1].v;
            r_fin.sing  <= r_uv[UV_DEPTH-1].sing;
            r_fin.sc    <= r_uv[UV_DEPTH-1].sing ? '0 : sec_q;
            r_fin.ut    <= r_uv[UV_DEPTH-1].sing ? '0 : mulq(r_uv[UV_DEPTH-1].u, tan_q);
            r_fin.vt    <= r_uv[UV_DEPTH-1].sing ? '0 : mulq(r_uv[UV_DEPTH-1].v, tan_q);
            r_fin.ssq   <= r_uv[UV_DEPTH-1].sing ? '0 : mulq(sec_q, sec_q);
            r_fin.usc   <= r_uv[UV_DEPTH-1].sing ? '0 : mulq(r_uv[UV_DEPTH-1].u, sec_q);
            r_fin.vsc   <= r_uv[UV_DEPTH-1].sing ? '0 : mulq(r_uv[UV_DEPTH-1].v, sec_q);

            r_out.roll_out  <= angle16(34'(r_fin.roll) + 34'(r_fin.dp) + 34'(r_fin.ut));
            r_out.pitch_out <= angle16(34'(r_fin.pitch) + 34'(r_fin.v));
            r_out.yaw_out   <= angle16(34'(r_fin.yaw) + 34'(r_fin.usc));
            r_out.jrr       <= sat32(34'sd65536 + 34'(r_fin.vt));
            r_out.jrp       <= mulq(r_fin.u, r_fin.ssq);
            r_out.jpr       <= sat32(-34'(r_fin.u));
            r_out.jyr       <= r_fin.vsc;
            r_out.jyp       <= mulq(r_fin.ut, r_fin.sc);
            r_out.sing      <= r_fin.sing;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[PIPE_LAT-2:0], accept};
        end
    end

    // park a refused result; the pipe holds until the skid drains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (o_result.ready) begin
                r_skid_v <= 1'b0;
            end
        end else if (r_v[PIPE_LAT-1] && !o_result.ready) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v && r_v[PIPE_LAT-1] && !o_result.ready) begin
            r_skid <= r_out;
        end
    end

    assign res_sel = r_skid_v ? r_skid : r_out;

    assign o_result.valid          = r_skid_v || r_v[PIPE_LAT-1];
    assign o_result.roll_out       = res_sel.roll_out;
    assign o_result.pitch_out      = res_sel.pitch_out;
    assign o_result.yaw_out        = res_sel.yaw_out;
    assign o_result.jac_roll_roll  = res_sel.jrr;
    assign o_result.jac_roll_pitch = res_sel.jrp;
    assign o_result.jac_pitch_roll = res_sel.jpr;
    assign o_result.jac_yaw_roll   = res_sel.jyr;
    assign o_result.jac_yaw_pitch  = res_sel.jyp;
    assign o_result.singular       = res_sel.sing;

`ifndef NO_ASSERTIONS
    a_skid_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> o_result.valid)
        else $error("skid beat not presented");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v && !o_result.ready |=> r_skid_v && $stable(r_skid))
        else $error("skid beat lost while stalled");

    a_sing_jac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.singular |->
            o_result.jac_roll_roll == 32'sh0001_0000 && o_result.jac_roll_pitch == '0
            && o_result.jac_yaw_roll == '0 && o_result.jac_yaw_pitch == '0)
        else $error("singular result carries divided terms");

    a_period_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> r_sample_period == SAMPLE_PERIOD_RESET)
        else $error("sample period not restored by reset");
`endif

endmodule

FILE: verif/eap_attitude_checker.sv
// Checker for the Euler attitude propagation block: watches the item, result and
// sample period channels, predicts each result and compares it field by field.
// Depends on the channel interfaces (design/eap_if.sv).
module eap_attitude_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    eap_in_if      i_item_ch,
    eap_out_if     i_result_ch,
    eap_cfg_if     i_cfg_ch,
    output int     o_fail_count,
    output int     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint GAIN_Q30    = 652032874;
    localparam longint PI_Q28      = 843314857;
    localparam longint TWO_PI_Q28  = 1686629713;
    localparam longint HALF_PI_Q28 = 421657428;
    localparam longint S32_MAX     = 64'sh7fff_ffff;
    localparam longint S32_MIN     = -64'sh8000_0000;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic signed [31:0] j_rr;
        logic signed [31:0] j_rp;
        logic signed [31:0] j_pr;
        logic signed [31:0] j_yr;
        logic signed [31:0] j_yp;
        logic               sing;
    } t_attitude;

    const longint arctan_q28 [24] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
        4193963, 2097109, 1048571, 524287, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048,
        1024, 512, 256, 128, 64, 32
    };

    t_attitude   attitude_q[$];
    logic [15:0] period;
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = attitude_q.size();

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint sat_w(longint v);
        return clip(v, S32_MIN, S32_MAX);
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        return sat_w((sat_w(a) * sat_w(b)) >>> 16);
    endfunction

    // truncating divide, magnitude capped at 2^32 before saturation
    function automatic longint fx_div(longint num, longint den);
        logic   neg;
        longint n;
        longint d;
        longint q;
        neg = (num < 0) != (den < 0);
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        q = n / d;
        if (q > (64'sd1 <<< 32))
            q = 64'sd1 <<< 32;
        return sat_w(neg ? -q : q);
    endfunction

    function automatic void sin_cos(input logic signed [15:0] ang,
                                    output longint s16, output longint c16);
        longint z;
        longint x;
        longint y;
        longint t;
        logic   flip;
        z = longint'(ang) * 65536;
        x = GAIN_Q30;
        y = 0;
        flip = 1'b0;
        if (z > PI_Q28)
            z -= TWO_PI_Q28;
        else if (z < -PI_Q28)
            z += TWO_PI_Q28;
        // fold into the right half plane; both results change sign
        if (z > HALF_PI_Q28) begin
            z -= PI_Q28;
            flip = 1'b1;
        end else if (z < -HALF_PI_Q28) begin
            z += PI_Q28;
            flip = 1'b1;
        end
        for (int i = 0; i < 24; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z -= arctan_q28[i];
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z += arctan_q28[i];
            end
            x = t;
        end
        x = (x + 8192) >>> 14;
        y = (y + 8192) >>> 14;
        s16 = flip ? -y : y;
        c16 = flip ? -x : x;
    endfunction

    function automatic t_attitude propagate(logic signed [15:0] roll_i,
                                            logic signed [15:0] pitch_i,
                                            logic signed [15:0] yaw_i,
                                            logic signed [15:0] p_i,
                                            logic signed [15:0] q_i,
                                            logic signed [15:0] r_i,
                                            logic [15:0] dt_i);
        t_attitude a;
        longint sr, cr, sp, cp, tn, sc, dt, dp, dq, dr, u, v;
        sin_cos(roll_i, sr, cr);
        sin_cos(pitch_i, sp, cp);
        tn = 0;
        sc = 0;
        if (cp != 0) begin
            tn = fx_div(sp * 65536, cp);
            sc = fx_div(64'sd1 <<< 32, cp);
        end
        dt = longint'(dt_i);
        dp = fx_mul(dt, longint'(p_i) * 32);
        dq = fx_mul(dt, longint'(q_i) * 32);
        dr = fx_mul(dt, longint'(r_i) * 32);
        u = sat_w(fx_mul(dq, sr) + fx_mul(dr, cr));
        v = sat_w(fx_mul(dq, cr) - fx_mul(dr, sr));
        a.roll  = 16'(clip((longint'(roll_i) * 16 + dp + fx_mul(u, tn)) >>> 4,
                           -32768, 32767));
        a.pitch = 16'(clip((longint'(pitch_i) * 16 + v) >>> 4, -32768, 32767));
        a.yaw   = 16'(clip((longint'(yaw_i) * 16 + fx_mul(u, sc)) >>> 4,
                           -32768, 32767));
        a.j_rr  = 32'(sat_w(65536 + fx_mul(v, tn)));
        a.j_rp  = 32'(fx_mul(u, fx_mul(sc, sc)));
        a.j_pr  = 32'(sat_w(-u));
        a.j_yr  = 32'(fx_mul(v, sc));
        a.j_yp  = 32'(fx_mul(fx_mul(u, tn), sc));
        a.sing  = (cp == 0);
        return a;
    endfunction

    task automatic compare_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_attitude want;
        if (!i_rst_n) begin
            period <= 16'd655;
            attitude_q.delete();
            fails = 0;
        end else begin
            if (i_cfg_ch.valid && i_cfg_ch.ready)
                period <= i_cfg_ch.data;
            if (i_item_ch.valid && i_item_ch.ready)
                attitude_q.push_back(propagate(i_item_ch.roll_in, i_item_ch.pitch_in,
                                               i_item_ch.yaw_in, i_item_ch.rate_x,
                                               i_item_ch.rate_y, i_item_ch.rate_z,
                                               period));
            if (i_result_ch.valid && i_result_ch.ready) begin
                if (attitude_q.size() == 0) begin
                    $error("result beat with nothing outstanding");
                    fails++;
                end else begin
                    want = attitude_q.pop_front();
                    compare_field("roll_out", want.roll, i_result_ch.roll_out);
                    compare_field("pitch_out", want.pitch, i_result_ch.pitch_out);
                    compare_field("yaw_out", want.yaw, i_result_ch.yaw_out);
                    compare_field("jac_roll_roll", want.j_rr,
                                  i_result_ch.jac_roll_roll);
                    compare_field("jac_roll_pitch", want.j_rp,
                                  i_result_ch.jac_roll_pitch);
                    compare_field("jac_pitch_roll", want.j_pr,
                                  i_result_ch.jac_pitch_roll);
                    compare_field("jac_yaw_roll", want.j_yr,
                                  i_result_ch.jac_yaw_roll);
                    compare_field("jac_yaw_pitch", want.j_yp,
                                  i_result_ch.jac_yaw_pitch);
                    compare_field("singular", want.sing, i_result_ch.singular);
                end
            end
        end
    end
endmodule

FILE: verif/tb_euler_attitude_propagation.sv
// Testbench top for the Euler attitude propagation block: clock, reset, item and
// sample period stimulus with random idling, watchdog and verdict.
// Depends on euler_attitude_propagation, the channel interfaces and eap_attitude_checker.
module tb_euler_attitude_propagation;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 5000;
    localparam logic signed [15:0] HALF_PI_Q12 = 16'sd6434;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   quiet_cycles;

    eap_in_if  item_ch ();
    eap_out_if result_ch ();
    eap_cfg_if cfg_ch ();

    euler_attitude_propagation u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    eap_attitude_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_ch    (item_ch),
        .i_result_ch  (result_ch),
        .i_cfg_ch     (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (item_ch.valid && item_ch.ready) ||
            (result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (pending != 0 || item_ch.valid || cfg_ch.valid) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic send_item(logic signed [15:0] roll, logic signed [15:0] pitch,
                             logic signed [15:0] yaw, logic signed [15:0] p,
                             logic signed [15:0] q, logic signed [15:0] r);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid    <= 1'b1;
        item_ch.roll_in  <= roll;
        item_ch.pitch_in <= pitch;
        item_ch.yaw_in   <= yaw;
        item_ch.rate_x   <= p;
        item_ch.rate_y   <= q;
        item_ch.rate_z   <= r;
        // hold the beat until ready is seen ahead of an edge
        forever begin
            @(negedge i_clk);
            if (item_ch.ready) break;
        end
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_period(logic [15:0] value);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        forever begin
            @(negedge i_clk);
            if (cfg_ch.ready) break;
        end
        @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick_angle();
        case ($urandom_range(5))
            0: return HALF_PI_Q12 + 16'($signed($urandom_range(4)) - 2);
            1: return -HALF_PI_Q12 + 16'($signed($urandom_range(4)) - 2);
            2: return 16'($signed($urandom_range(25736)) - 12868);
            3: return 16'($signed($urandom_range(800)) - 400);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_rate();
        case ($urandom_range(3))
            0: return 16'($signed($urandom_range(4000)) - 2000);
            1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_items(int count);
        repeat (count)
            send_item(pick_angle(), pick_angle(), 16'($urandom),
                      pick_rate(), pick_rate(), pick_rate());
    endtask

    initial begin
        i_rst_n         = 1'b0;
        send_idle_pct   = 22;
        recv_idle_pct   = 63;
        item_ch.valid   = 1'b0;
        item_ch.roll_in = '0;
        item_ch.pitch_in = '0;
        item_ch.yaw_in  = '0;
        item_ch.rate_x  = '0;
        item_ch.rate_y  = '0;
        item_ch.rate_z  = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset period, extremes, singular pitch, wrap boundaries
        send_item(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_item(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_item(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_item(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
        for (int d = -3; d <= 3; d++) begin
            send_item(16'sd1000, HALF_PI_Q12 + 16'(d), 16'sd0, 16'sd500, 16'sd700, 16'sd900);
            send_item(-16'sd1000, -HALF_PI_Q12 + 16'(d), 16'sd0, -16'sd500, 16'sd700, -16'sd900);
        end
        send_item(16'sd12868, 16'sd12868, 16'sd12868, 16'sd2048, 16'sd2048, 16'sd2048);
        send_item(-16'sd12868, -16'sd12869, 16'sd12869, -16'sd2048, 16'sd2048, -16'sd2048);
        send_item(16'sd19302, 16'sd19302, 16'sd0, 16'sh7fff, 16'sh8000, 16'sh7fff);
        send_item(-16'sd1, 16'sd1, -16'sd1, -16'sd1, 16'sd1, -16'sd1);

        write_period(16'hffff);
        random_items(250);
        write_period(16'd1);
        random_items(200);
        send_idle_pct = 63;
        recv_idle_pct = 22;
        write_period(16'($urandom_range(65535, 1)));
        random_items(250);
        write_period(16'hffff);
        random_items(200);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_period(16'($urandom_range(2000, 1)));
        random_items(300);
        write_period(16'd655);
        random_items(300);

        wait_idle();
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

FILE: sim.f
design/eap_pkg.sv
design/eap_if.sv
design/eap_cordic.sv
design/eap_div.sv
design/euler_attitude_propagation.sv
verif/eap_attitude_checker.sv
verif/tb_euler_attitude_propagation.sv
